// ----- sv/xpd_pkg.sv -----
`timescale 1ns / 1ps

package xpd_pkg;

  // Largest accepted payload length by default
  localparam int MAX_PAYLOAD_DEF = 64;
  // Start byte, length byte and two command bytes
  localparam int HEADER_BYTES    = 4;
  localparam int BYTE_SHIFT      = 8;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;

  // Positions of the header bytes within a frame
  localparam int POS_START  = 0;
  localparam int POS_LEN    = 1;
  localparam int POS_CMD_HI = 2;
  localparam int POS_CMD_LO = 3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_begin;
  } xpd_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic [15:0] command_word;
    logic [6:0]  payload_length;
    logic        start_error;
    logic        length_error;
    logic        checksum_error;
  } xpd_out_t;

  // Parser result toward the output register
  typedef struct packed {
    logic     valid;
    xpd_out_t item;
  } xpd_res_t;

endpackage

// ----- sv/xpd_in_stage.sv -----
`timescale 1ns / 1ps

module xpd_in_stage import xpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  xpd_in_t in_data_i,
  input  logic    take_i,
  output logic    item_valid_o,
  output xpd_in_t item_o
);

  logic    valid_q, valid_d;
  xpd_in_t data_q;
  logic    accept;

  // Stall only while a held byte cannot advance this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ----- sv/xpd_parser.sv -----
`timescale 1ns / 1ps

module xpd_parser import xpd_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  xpd_in_t    item_i,
  input  logic [7:0] marker_i,
  output xpd_res_t   res_o
);

  localparam int POS_W = $clog2(MaxPayload + HEADER_BYTES + 1);
  localparam int LEN_W = $clog2(MaxPayload + 1);
  localparam logic [7:0] MAX_B = 8'(MaxPayload);

  logic [POS_W-1:0] pos_q, pos_d, pos_e;
  logic             active_q, active_d, active_e;
  logic [7:0]       xor_q, xor_d, xor_e;
  logic [15:0]      cmd_q, cmd_d, cmd_e;
  logic [LEN_W-1:0] len_q, len_d, len_e;
  logic [1:0]       err_q, err_d, err_e;

  logic [7:0]       b;
  logic [POS_W-1:0] idx_w;
  logic [POS_W+5:0] idx_ext;
  logic [LEN_W+6:0] len_ext;

  assign b       = item_i.rx_byte;
  assign idx_w   = pos_e - POS_W'(HEADER_BYTES);
  assign idx_ext = {6'b0, idx_w};
  assign len_ext = {7'b0, len_e};

  // Effective state: a begin marker restarts the frame at this byte
  always_comb begin
    pos_e    = pos_q;
    active_e = active_q;
    xor_e    = xor_q;
    cmd_e    = cmd_q;
    len_e    = len_q;
    err_e    = err_q;
    if (item_i.frame_begin) begin
      pos_e    = '0;
      active_e = 1'b1;
      xor_e    = '0;
      cmd_e    = '0;
      len_e    = '0;
      err_e    = '0;
    end
  end

  always_comb begin
    pos_d    = pos_e;
    active_d = active_e;
    xor_d    = xor_e;
    cmd_d    = cmd_e;
    len_d    = len_e;
    err_d    = err_e;
    res_o    = '0;
    if (active_e) begin
      xor_d = xor_e ^ b;
      pos_d = pos_e + POS_W'(1);
      if (pos_e == POS_W'(POS_START)) begin
        if (b != marker_i) begin
          err_d[0] = 1'b1;
        end
      end else if (pos_e == POS_W'(POS_LEN)) begin
        // Oversize length counts as zero payload bytes
        if (b > MAX_B) begin
          err_d[1] = 1'b1;
          len_d    = '0;
        end else begin
          len_d = LEN_W'(b);
        end
      end else if (pos_e == POS_W'(POS_CMD_HI)) begin
        cmd_d = 16'(b) << BYTE_SHIFT;
      end else if (pos_e == POS_W'(POS_CMD_LO)) begin
        cmd_d = cmd_e | 16'(b);
      end else if (pos_e < POS_W'(HEADER_BYTES) + POS_W'(len_e)) begin
        res_o.valid              = 1'b1;
        res_o.item.item_kind     = KIND_PAYLOAD;
        res_o.item.payload_byte  = b;
        res_o.item.payload_index = idx_ext[5:0];
      end else begin
        // Checksum byte closes the frame
        res_o.valid               = 1'b1;
        res_o.item.item_kind      = KIND_SUMMARY;
        res_o.item.command_word   = cmd_e;
        res_o.item.payload_length = len_ext[6:0];
        res_o.item.start_error    = err_e[0];
        res_o.item.length_error   = err_e[1];
        res_o.item.checksum_error = (b != xor_e);
        active_d = 1'b0;
        pos_d    = '0;
        xor_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      xor_q    <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      err_q    <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      xor_q    <= xor_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      err_q    <= err_d;
    end
  end

  a_summary_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.valid && (res_o.item.item_kind == KIND_SUMMARY) |=> !active_q)
    else $error("frame still active after summary");

  a_payload_past_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.valid && (res_o.item.item_kind == KIND_PAYLOAD)
    |=> pos_q > POS_W'(HEADER_BYTES))
    else $error("payload byte emitted inside header");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (pos_q == '0) && (xor_q == '0))
    else $error("idle parser holds stale position or checksum");

endmodule

// ----- sv/xpd_out_stage.sv -----
`timescale 1ns / 1ps

module xpd_out_stage import xpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  xpd_res_t res_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output xpd_out_t out_data_o
);

  logic     valid_q, valid_d;
  xpd_out_t data_q;
  logic     load_res;

  // Register can take a new result when empty or being drained
  assign ready_o  = !valid_q || !out_stall_i;
  assign load_res = ready_o && load_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      data_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/xor_packet_deframer_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (xpd_in_t)
// out       output     out_valid_o / out_stall_i out_data_o (xpd_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (start marker)
//
// One byte per cycle sustained while out_stall_i is low; a transferred byte is held in
// the input register, and its result is loaded into the result register as it advances.
// The parser state update and result selection sit between the two registers.
// Reset clears the frame state and the handshake flags; start marker resets to 0xAA.
// A stalled result register holds the byte in the input register, which then
// stalls the input channel; a byte that gives no result still waits its turn.

module xor_packet_deframer_core import xpd_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  xpd_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output xpd_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] marker_q;
  logic       item_valid;
  xpd_in_t    item;
  logic       out_ready;
  logic       fire;
  xpd_res_t   res;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= START_MARKER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      marker_q <= cfg_data_i;
    end
  end

  // Advance the held byte whenever the result register can take its result
  assign fire = item_valid && out_ready;

  xpd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  xpd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .marker_i (marker_q),
    .res_o    (res)
  );

  xpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_cfg_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> marker_q == $past(cfg_data_i))
    else $error("start marker write lost");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_no_fire_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !fire)
    else $error("byte advanced into a stalled result register");

endmodule

// ----- tb/sv/xor_packet_deframer_core_test.sv -----
`timescale 1ns / 1ps

module xor_packet_deframer_core_test;
  import xpd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  xpd_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  xpd_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'h00;

  xor_packet_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered, and results the deframer still owes us
  xpd_in_t  rx_bytes_q[$];
  xpd_out_t due_results_q[$];

  int err_cnt = 0;
  bit quiet_tail = 1'b0;

  // Shadow of the deframer: start marker plus the frame parse state
  logic [7:0]  exp_marker = START_MARKER_RST;
  logic        f_active = 1'b0;
  logic [6:0]  f_pos = '0;
  logic [7:0]  f_xor = '0;
  logic [15:0] f_cmd = '0;
  logic [6:0]  f_len = '0;
  logic        f_start_err = 1'b0;
  logic        f_len_err = 1'b0;

  // Advance the shadow parser by one transferred byte; queue any result it owes
  function automatic void deframe_byte(xpd_in_t it);
    xpd_out_t r;
    r = '0;
    if (it.frame_begin) begin
      // A new frame always restarts the parse; an open frame is dropped silently
      f_active    = 1'b1;
      f_pos       = '0;
      f_xor       = '0;
      f_cmd       = '0;
      f_len       = '0;
      f_start_err = 1'b0;
      f_len_err   = 1'b0;
    end
    if (!f_active) return;
    if (f_pos == POS_START) begin
      if (it.rx_byte != exp_marker) f_start_err = 1'b1;
    end else if (f_pos == POS_LEN) begin
      // Oversize length is flagged and parsed as an empty payload
      if (it.rx_byte > MAX_PAYLOAD_DEF) begin
        f_len_err = 1'b1;
        f_len     = '0;
      end else begin
        f_len = it.rx_byte[6:0];
      end
    end else if (f_pos == POS_CMD_HI) begin
      f_cmd = {it.rx_byte, 8'h00};
    end else if (f_pos == POS_CMD_LO) begin
      f_cmd[7:0] = it.rx_byte;
    end else if (int'(f_pos) < HEADER_BYTES + int'(f_len)) begin
      r.item_kind     = KIND_PAYLOAD;
      r.payload_byte  = it.rx_byte;
      r.payload_index = 6'(int'(f_pos) - HEADER_BYTES);
      due_results_q.push_back(r);
    end else begin
      // Checksum position comes from the length field, never from the byte value
      r.item_kind      = KIND_SUMMARY;
      r.command_word   = f_cmd;
      r.payload_length = f_len;
      r.start_error    = f_start_err;
      r.length_error   = f_len_err;
      r.checksum_error = (it.rx_byte != f_xor);
      due_results_q.push_back(r);
      f_active = 1'b0;
      f_pos    = '0;
      f_xor    = '0;
      return;
    end
    f_xor = f_xor ^ it.rx_byte;
    f_pos = f_pos + 7'd1;
  endfunction

  // Sender: offer queued bytes, with random gap bursts whose density is redrawn
  // periodically (rate 0 gives a stretch with no gaps)
  int tx_tick = 0;
  int tx_rate = 0;
  int tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) deframe_byte(in_data_i);
      tx_tick++;
      if (tx_tick % 64 == 0) tx_rate = $urandom_range(0, 3);
      // Hold valid and payload while the transfer is stalled
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap == 0 && !quiet_tail && $urandom_range(0, 7) < tx_rate)
          tx_gap = $urandom_range(1, 6);
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= rx_bytes_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Receiver: check every transfer against the oldest owed result, stall at random,
  // and once hold off long enough for the deframer to back up into its input
  int sink_tick = 0;
  int sink_rate = 0;
  int sink_gap = 0;
  int sink_hold = 0;
  int results_seen = 0;
  xpd_out_t exp_r;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data_o);
          err_cnt++;
        end else begin
          exp_r = due_results_q.pop_front();
          check_field("item_kind", exp_r.item_kind, out_data_o.item_kind);
          check_field("payload_byte", exp_r.payload_byte, out_data_o.payload_byte);
          check_field("payload_index", exp_r.payload_index, out_data_o.payload_index);
          check_field("command_word", exp_r.command_word, out_data_o.command_word);
          check_field("payload_length", exp_r.payload_length, out_data_o.payload_length);
          check_field("start_error", exp_r.start_error, out_data_o.start_error);
          check_field("length_error", exp_r.length_error, out_data_o.length_error);
          check_field("checksum_error", exp_r.checksum_error, out_data_o.checksum_error);
        end
        results_seen++;
        if (results_seen == 250) sink_hold = 120;
      end
      sink_tick++;
      if (sink_tick % 64 == 0) sink_rate = $urandom_range(0, 3);
      if (sink_gap == 0 && !quiet_tail && $urandom_range(0, 7) < sink_rate)
        sink_gap = $urandom_range(1, 6);
      if (sink_hold > 0) begin
        sink_hold--;
        out_stall_i <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic beg);
    xpd_in_t it;
    it.rx_byte     = b;
    it.frame_begin = beg;
    rx_bytes_q.push_back(it);
  endtask

  // Queue one frame; a cut frame stops early so that the next frame drops it
  task automatic push_frame(input logic [7:0] lead, input logic [7:0] decl,
                            input logic [15:0] cmd, input bit bad_sum, input bit cut);
    logic [7:0] fb[$];
    logic [7:0] csum;
    int n_pay;
    int n_keep;
    fb = '{lead, decl, cmd[15:8], cmd[7:0]};
    n_pay = (decl > MAX_PAYLOAD_DEF) ? 0 : int'(decl);
    repeat (n_pay) fb.push_back(8'($urandom));
    csum = '0;
    foreach (fb[i]) csum = csum ^ fb[i];
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    fb.push_back(csum);
    n_keep = cut ? $urandom_range(1, fb.size() - 1) : fb.size();
    for (int i = 0; i < n_keep; i++) push_byte(fb[i], i == 0);
  endtask

  // Mostly well-formed frames with random content; the rest are cut frames,
  // wrong start bytes, oversize lengths, bad checksums and stray bytes
  task automatic run_traffic(input int n_items);
    int sent;
    int before_n;
    int pick;
    logic [7:0] lead;
    logic [7:0] decl;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Stray byte: ignored outside a frame, extends a cut frame otherwise
        push_byte(8'($urandom), 1'b0);
      end else begin
        lead = ($urandom_range(0, 99) < 85) ? exp_marker
                                            : exp_marker ^ 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 70)      decl = 8'($urandom_range(0, 8));
        else if (pick < 80) decl = 8'($urandom_range(9, 63));
        else if (pick < 88) decl = 8'(MAX_PAYLOAD_DEF);
        else if (pick < 92) decl = 8'(MAX_PAYLOAD_DEF + 1);
        else                decl = 8'($urandom_range(0, 255));
        before_n = rx_bytes_q.size();
        push_frame(lead, decl, 16'($urandom), $urandom_range(0, 99) < 15,
                   $urandom_range(0, 99) < 12);
        sent += rx_bytes_q.size() - before_n;
      end
    end
  endtask

  // Wait until every byte is transferred and every result checked, then let
  // the two pipeline registers drain bytes that owe no result
  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || in_valid_i || due_results_q.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    exp_marker = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] pz;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset start marker
    push_byte(8'h5A, 1'b0);                               // stray byte, no frame open
    push_frame(8'hAA, 8'h00, 16'hFFFF, 1'b0, 1'b0);       // empty payload, good checksum
    pz = 8'hAA ^ 8'h01 ^ 8'h12 ^ 8'h34;                   // checksum byte of zero
    push_byte(8'hAA, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(pz, 1'b0);
    push_byte(8'h00, 1'b0);
    push_frame(8'h00, 8'h00, 16'h0000, 1'b1, 1'b0);       // bad start, bad checksum
    push_frame(8'hAA, 8'hFF, 16'h8001, 1'b0, 1'b0);       // oversize length
    push_frame(8'hAA, 8'h02, 16'h1234, 1'b0, 1'b1);       // dropped by the next frame
    push_frame(8'hAA, 8'h03, 16'h00FF, 1'b0, 1'b0);
    wait_drained();

    write_marker(8'h00);
    run_traffic(300);
    wait_drained();

    write_marker(8'hFF);
    run_traffic(300);
    wait_drained();

    write_marker(8'($urandom));
    run_traffic(300);
    wait_drained();

    // Last stretch at full rate on both sides
    write_marker(8'h55);
    quiet_tail = 1'b1;
    run_traffic(450);
    wait_drained();

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
